### hdl/mlfd_pkg.sv
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the sync-word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

    // Width of one link byte.
    localparam int unsigned BYTE_W = 8;
    // Width of the payload length field.
    localparam int unsigned LEN_W = 16;

    // Sync word bytes 'H', 'C', 'M'.
    localparam logic [BYTE_W-1:0] SYNC_0 = 8'h48;
    localparam logic [BYTE_W-1:0] SYNC_1 = 8'h43;
    localparam logic [BYTE_W-1:0] SYNC_2 = 8'h4D;

    // One result of the parser, with its valid flag.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] frame_object_id;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic              end_of_frame;
    } mlfd_result_t;

endpackage

### hdl/mlfd_if.sv
// ----------------------------------------------------------------------------
// mlfd_byte_if / mlfd_frame_if
// Valid/ready channels for received link bytes and for deframed results.
// ----------------------------------------------------------------------------
interface mlfd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [mlfd_pkg::BYTE_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfd_frame_if;
    logic                          valid;
    logic                          ready;
    logic [mlfd_pkg::BYTE_W-1:0]   frame_object_id;
    logic [mlfd_pkg::BYTE_W-1:0]   payload_byte;
    logic                          has_data;
    logic                          end_of_frame;

    modport source (output valid, output frame_object_id, output payload_byte,
                    output has_data, output end_of_frame, input ready);
    modport sink   (input valid, input frame_object_id, input payload_byte,
                    input has_data, input end_of_frame, output ready);
endinterface

### hdl/mlfd_parser.sv
// ----------------------------------------------------------------------------
// mlfd_parser
// Header state machine: sync hunt, length and object id capture, and payload
// countdown. Consumes one byte on each step and gives at most one result.
// ----------------------------------------------------------------------------
module mlfd_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [mlfd_pkg::BYTE_W-1:0]   rx_byte,
    output mlfd_pkg::mlfd_result_t        result
);

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_SYNC1  = 3'd1;
    localparam logic [2:0] PH_SYNC2  = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_LEN_LO = 3'd4;
    localparam logic [2:0] PH_OBJ    = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;

    logic [2:0]                     phase_reg, phase_next;
    logic [mlfd_pkg::BYTE_W-1:0]    length_high_reg, length_high_next;
    logic [mlfd_pkg::LEN_W-1:0]     bytes_left_reg, bytes_left_next;
    logic [mlfd_pkg::BYTE_W-1:0]    current_object_reg, current_object_next;
    logic [2:0]                     restart_phase;
    logic [mlfd_pkg::LEN_W-1:0]     bytes_dec;

    // A byte that breaks the sync word may itself open a new one.
    assign restart_phase = (rx_byte == mlfd_pkg::SYNC_0) ? PH_SYNC1 : PH_HUNT;
    assign bytes_dec     = bytes_left_reg - {{(mlfd_pkg::LEN_W-1){1'b0}}, 1'b1};

    // Next state and result for the byte at hand.
    always_comb
    begin
        phase_next                = phase_reg;
        length_high_next          = length_high_reg;
        bytes_left_next           = bytes_left_reg;
        current_object_next       = current_object_reg;
        result                    = '0;
        result.frame_object_id    = current_object_reg;
        case (phase_reg)
            PH_SYNC1:
            begin
                phase_next = (rx_byte == mlfd_pkg::SYNC_1) ? PH_SYNC2 : restart_phase;
            end
            PH_SYNC2:
            begin
                phase_next = (rx_byte == mlfd_pkg::SYNC_2) ? PH_LEN_HI : restart_phase;
            end
            PH_LEN_HI:
            begin
                length_high_next = rx_byte;
                phase_next       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                bytes_left_next = {length_high_reg, rx_byte};
                phase_next      = PH_OBJ;
            end
            PH_OBJ:
            begin
                current_object_next    = rx_byte;
                result.frame_object_id = rx_byte;
                if (bytes_left_reg == '0)
                begin
                    // Empty frame: a single notice without data.
                    result.valid        = 1'b1;
                    result.end_of_frame = 1'b1;
                    phase_next          = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (bytes_left_reg == '0)
                begin
                    phase_next = restart_phase;
                end
                else
                begin
                    bytes_left_next     = bytes_dec;
                    result.valid        = 1'b1;
                    result.payload_byte = rx_byte;
                    result.has_data     = 1'b1;
                    result.end_of_frame = (bytes_dec == '0);
                    if (bytes_dec == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            default:
            begin
                phase_next = restart_phase;
            end
        endcase
        if (!step)
        begin
            result.valid = 1'b0;
        end
    end

    // State registers advance only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            length_high_reg    <= '0;
            bytes_left_reg     <= '0;
            current_object_reg <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            bytes_left_reg     <= bytes_left_next;
            current_object_reg <= current_object_next;
        end
    end

endmodule

### hdl/magic_length_frame_deframer.sv
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Sync-word, length-prefixed byte deframer with valid/ready channels.
// ----------------------------------------------------------------------------
// The block takes one link byte per cycle and keeps that rate for as long as
// the result side takes its requests. A byte passes an input register, the
// header state machine, and a result register in that order on its way to
// tx. Header bytes give no result; the object id byte of a zero-length
// frame gives one notice with has_data low. The only stall comes from the
// result register: while it holds a request that tx does not take, the
// state machine holds, and rx.ready falls once the input register is full.
module magic_length_frame_deframer (
    input  logic               clk,
    input  logic               rst_n,
    mlfd_byte_if.sink          rx,
    mlfd_frame_if.source       tx
);

    logic                            rx_valid_reg, rx_valid_next;
    logic [mlfd_pkg::BYTE_W-1:0]     rx_byte_reg;
    logic                            tx_valid_reg, tx_valid_next;
    mlfd_pkg::mlfd_result_t          tx_data_reg;
    mlfd_pkg::mlfd_result_t          result;
    logic                            advance;
    logic                            step;
    logic                            rx_take;

    // The pipeline moves whenever the result register is free or drained.
    assign advance  = !tx_valid_reg || tx.ready;
    assign rx.ready = !rx_valid_reg || advance;
    assign rx_take  = rx.valid && rx.ready;
    assign step     = rx_valid_reg && advance;

    mlfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx_byte_reg),
        .result  (result)
    );

    // Valid flags of the two pipeline registers.
    always_comb
    begin
        rx_valid_next = rx_valid_reg;
        if (rx_take)
        begin
            rx_valid_next = 1'b1;
        end
        else if (advance)
        begin
            rx_valid_next = 1'b0;
        end
        tx_valid_next = advance ? result.valid : tx_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid_reg <= 1'b0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            rx_valid_reg <= rx_valid_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            rx_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            tx_data_reg <= result;
        end
    end

    assign tx.valid           = tx_valid_reg;
    assign tx.frame_object_id = tx_data_reg.frame_object_id;
    assign tx.payload_byte    = tx_data_reg.payload_byte;
    assign tx.has_data        = tx_data_reg.has_data;
    assign tx.end_of_frame    = tx_data_reg.end_of_frame;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync-word, length-prefixed byte deframer.
// A queue of link bytes (directed frames first, then random frames, broken
// sync words and line noise) is sent over rx with random gaps. Each accepted
// byte runs through a local deframer model, and its results are queued and
// compared field by field with what tx delivers under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Quiet cycles (no request taken on either side) before the run is aborted.
    localparam int unsigned QUIET_LIMIT = 5000;
    // Cycles allowed after the last expected result for stray results to show.
    localparam int unsigned DRAIN_CYCLES = 20;
    // Target number of link bytes, and the tail that runs with no idling.
    localparam int unsigned LINK_BYTES = 1600;
    localparam int unsigned CALM_TAIL = 200;
    // Mismatches that are printed in full.
    localparam int unsigned SHOWN_ERRORS = 10;

    // Parser phases of the local deframer model.
    typedef enum logic [2:0] {
        ST_SEEK_H,
        ST_SEEK_C,
        ST_SEEK_M,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_OBJ_ID,
        ST_PAYLOAD,
        ST_SPARE
    } seek_phase_t;

    // One deframed result as tx should present it.
    typedef struct {
        logic [mlfd_pkg::BYTE_W-1:0] object_id;
        logic [mlfd_pkg::BYTE_W-1:0] payload;
        logic                        has_data;
        logic                        last;
    } frame_out_t;

    // One link byte waiting to be sent; hold makes the sender wait for
    // every outstanding result before offering it.
    typedef struct {
        logic [mlfd_pkg::BYTE_W-1:0] data;
        bit                          hold;
    } link_item_t;

    logic clk;
    logic rst_n;

    mlfd_byte_if  rx_if ();
    mlfd_frame_if tx_if ();

    magic_length_frame_deframer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    link_item_t  link_q[$];
    frame_out_t  due_results[$];

    // Model state.
    seek_phase_t                 seek_phase;
    logic [mlfd_pkg::BYTE_W-1:0] len_hi;
    logic [mlfd_pkg::LEN_W-1:0]  remaining;
    logic [mlfd_pkg::BYTE_W-1:0] object_id;

    int unsigned error_count;
    int unsigned quiet_cycles;
    int unsigned send_gap;
    int unsigned take_gap;

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A byte that breaks the sync word restarts the match if it is 'H'.
    function automatic seek_phase_t resync(input logic [mlfd_pkg::BYTE_W-1:0] b);
        return (b == mlfd_pkg::SYNC_0) ? ST_SEEK_C : ST_SEEK_H;
    endfunction

    // Advance the deframer model by one link byte and queue any result.
    function automatic void deframe_byte(input logic [mlfd_pkg::BYTE_W-1:0] b);
        frame_out_t r;
        case (seek_phase)
            ST_SEEK_C: seek_phase = (b == mlfd_pkg::SYNC_1) ? ST_SEEK_M : resync(b);
            ST_SEEK_M: seek_phase = (b == mlfd_pkg::SYNC_2) ? ST_LEN_HI : resync(b);
            ST_LEN_HI:
            begin
                len_hi = b;
                seek_phase = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                remaining = {len_hi, b};
                seek_phase = ST_OBJ_ID;
            end
            ST_OBJ_ID:
            begin
                object_id = b;
                if (remaining == '0)
                begin
                    // Empty frame: a single notice without data.
                    r = '{object_id, '0, 1'b0, 1'b1};
                    due_results = {due_results, r};
                    seek_phase = ST_SEEK_H;
                end
                else
                begin
                    seek_phase = ST_PAYLOAD;
                end
            end
            ST_PAYLOAD:
            begin
                if (remaining == '0)
                begin
                    seek_phase = resync(b);
                end
                else
                begin
                    remaining = remaining - 1'b1;
                    r = '{object_id, b, 1'b1, remaining == '0};
                    due_results = {due_results, r};
                    if (remaining == '0)
                        seek_phase = ST_SEEK_H;
                end
            end
            default: seek_phase = resync(b);
        endcase
    endfunction

    function automatic void push_byte(input logic [mlfd_pkg::BYTE_W-1:0] b,
                                      input bit hold = 1'b0);
        link_item_t it;
        it.data = b;
        it.hold = hold;
        link_q = {link_q, it};
    endfunction

    // A random byte that often is one of the sync characters.
    function automatic logic [mlfd_pkg::BYTE_W-1:0] syncish_byte();
        logic [mlfd_pkg::BYTE_W-1:0] b;
        case ($urandom_range(0, 5))
            0: b = mlfd_pkg::SYNC_0;
            1: b = mlfd_pkg::SYNC_1;
            2: b = mlfd_pkg::SYNC_2;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // A well-formed frame with random payload.
    function automatic void push_frame(input int unsigned len,
                                       input logic [mlfd_pkg::BYTE_W-1:0] obj,
                                       input bit hold);
        logic [mlfd_pkg::LEN_W-1:0] l;
        l = 16'(len);
        push_byte(mlfd_pkg::SYNC_0, hold);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_2);
        push_byte(l[15:8]);
        push_byte(l[7:0]);
        push_byte(obj);
        for (int unsigned i = 0; i < len; i++)
            push_byte(($urandom_range(0, 7) == 0) ? syncish_byte()
                                                  : 8'($urandom_range(0, 255)));
    endfunction

    function automatic void note_mismatch(input string field, input int exp_v, input int got_v);
        error_count++;
        if (error_count <= SHOWN_ERRORS)
            $display("mismatch on %s: expected %0h, got %0h at %0t", field, exp_v, got_v, $realtime);
    endfunction

    // Driver: offers queued link bytes with random gaps; valid holds until taken.
    always @(posedge clk or negedge rst_n)
    begin
        bit                          fire;
        bit                          drive_v;
        logic [mlfd_pkg::BYTE_W-1:0] drive_b;
        if (!rst_n)
        begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= '0;
            send_gap = 0;
        end
        else
        begin
            fire = rx_if.valid && rx_if.ready;
            if (fire)
            begin
                void'(link_q.pop_front());
                deframe_byte(rx_if.rx_byte);
            end
            if (!rx_if.valid || fire)
            begin
                drive_v = 1'b0;
                drive_b = 8'($urandom_range(0, 255));
                if (send_gap > 0)
                    send_gap--;
                else if (link_q.size() == 0)
                    drive_v = 1'b0;
                else if (link_q[0].hold && due_results.size() != 0)
                    drive_v = 1'b0;
                else if (link_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(0, 3);
                else
                begin
                    drive_v = 1'b1;
                    drive_b = link_q[0].data;
                end
                rx_if.valid   <= drive_v;
                rx_if.rx_byte <= drive_b;
            end
        end
    end

    // Monitor: random back-pressure on tx and a field-by-field check.
    always @(posedge clk or negedge rst_n)
    begin
        frame_out_t exp_r;
        bit         take;
        if (!rst_n)
        begin
            tx_if.ready <= 1'b0;
            take_gap = 0;
        end
        else
        begin
            if (tx_if.valid && tx_if.ready)
            begin
                if (due_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("unexpected result: obj %0h data %0h has_data %0b eof %0b at %0t",
                                 tx_if.frame_object_id, tx_if.payload_byte, tx_if.has_data,
                                 tx_if.end_of_frame, $realtime);
                end
                else
                begin
                    exp_r = due_results.pop_front();
                    if (tx_if.frame_object_id !== exp_r.object_id)
                        note_mismatch("frame_object_id", exp_r.object_id, tx_if.frame_object_id);
                    if (tx_if.payload_byte !== exp_r.payload)
                        note_mismatch("payload_byte", exp_r.payload, tx_if.payload_byte);
                    if (tx_if.has_data !== exp_r.has_data)
                        note_mismatch("has_data", exp_r.has_data, tx_if.has_data);
                    if (tx_if.end_of_frame !== exp_r.last)
                        note_mismatch("end_of_frame", exp_r.last, tx_if.end_of_frame);
                end
            end
            take = 1'b1;
            if (take_gap > 0)
            begin
                take_gap--;
                take = 1'b0;
            end
            else if (link_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                take_gap = $urandom_range(0, 3);
                take = 1'b0;
            end
            tx_if.ready <= take;
        end
    end

    // Watchdog on cycles in which no request moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned pick;
        int unsigned len;
        bit          first_random;
        clk           = 1'b0;
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        tx_if.ready   = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        seek_phase    = ST_SEEK_H;
        len_hi        = '0;
        remaining     = '0;
        object_id     = '0;
        first_random  = 1'b1;

        // Empty frame after a doubled 'H' while waiting for 'C'.
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_2);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        // Noise byte breaking the sync, then 'H' restarting it while waiting for 'M'.
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(8'h00);
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_2);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(8'h00);
        // The sync word inside a payload is plain data.
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_2);
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'h5A);
        push_byte(mlfd_pkg::SYNC_0);
        push_byte(mlfd_pkg::SYNC_1);
        push_byte(mlfd_pkg::SYNC_2);

        // Random part: mostly frames, some noise and broken sync words.
        while (link_q.size() < LINK_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(syncish_byte());
            end
            else if (pick == 1)
            begin
                push_byte(mlfd_pkg::SYNC_0);
                if ($urandom_range(0, 1) == 1)
                    push_byte(mlfd_pkg::SYNC_1);
                push_byte(syncish_byte());
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    len = 0;
                else if ($urandom_range(0, 39) == 0)
                    len = $urandom_range(25, 300);
                else
                    len = $urandom_range(1, 24);
                push_frame(len, 8'($urandom_range(0, 255)),
                           first_random || $urandom_range(0, 49) == 0);
                first_random = 1'b0;
            end
        end
        // Close with a complete frame so the last byte gives a result.
        push_frame($urandom_range(1, 8), 8'($urandom_range(0, 255)), 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (link_q.size() != 0 || rx_if.valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### magic_length_frame_deframer.f
hdl/mlfd_pkg.sv
hdl/mlfd_if.sv
hdl/mlfd_parser.sv
hdl/magic_length_frame_deframer.sv
tb/sv/tb_top.sv
